[hw/rtl/pse_pkg.sv]
// Shared types, constants and token decoding for the postfix stack evaluator.
package pse_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // Token queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Data path widths.
  localparam int DATA_W = 32;
  localparam int NUM_W = 31;
  localparam int FUNC_W = 3;
  localparam int STEP_W = $clog2(DATA_W);

  // Token kind codes on the func port.
  localparam logic [FUNC_W-1:0] FUNC_NUMBER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd4;

  // Internal operation after classification.
  typedef enum logic [2:0] {
    OP_NUM,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DROP
  } op_t;

  // One classified token as it travels through the queue.
  typedef struct packed {
    op_t              op;
    logic [NUM_W-1:0] number;
    logic             last;
  } tok_t;

  // Map a token kind to an operation; every unknown kind only drops operands.
  function automatic op_t classify(input logic [FUNC_W-1:0] func);
    op_t op;
    begin
      case (func)
        FUNC_NUMBER: op = OP_NUM;
        FUNC_ADD:    op = OP_ADD;
        FUNC_SUB:    op = OP_SUB;
        FUNC_MUL:    op = OP_MUL;
        FUNC_DIV:    op = OP_DIV;
        default:     op = OP_DROP;
      endcase
      return op;
    end
  endfunction

endpackage

[hw/rtl/pse_front.sv]
// Front end: accepts input items and classifies them into queued tokens.
module pse_front
  import pse_pkg::*;
(
  input  logic              push,
  output logic              full,
  input  logic [FUNC_W-1:0] func,
  input  logic [NUM_W-1:0]  number,
  input  logic              last,
  input  logic              q_full,
  output logic              q_wr,
  output tok_t              q_wdata
);

  // An item is taken whenever the token queue has room.
  assign full = q_full;
  assign q_wr = push && !q_full;

  // Decode the token kind and pass the operand and the end marker along.
  always_comb begin
    q_wdata.op     = classify(func);
    q_wdata.number = number;
    q_wdata.last   = last;
  end

endmodule

[hw/rtl/pse_queue.sv]
// Short token queue that decouples the front end from the stack engine.
module pse_queue
  import pse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  tok_t wdata,
  output logic q_full,
  input  logic rd,
  output tok_t rdata,
  output logic q_empty
);

  tok_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;

  assign q_full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign rdata   = slots[rptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (wr && !rd) begin
        fill <= fill + QCNT_W'(1);
      end else if (rd && !wr) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

[hw/rtl/pse_back.sv]
// Stack engine: runs tokens against the stack memory and produces results.
module pse_back
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tok_t              tok,
  input  logic              tok_empty,
  output logic              tok_pop,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] value,
  output logic              div_zero,
  output logic              stack_overflow
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_POP_B  = 8'b0000_0010,
    S_POP_A  = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_PUSH   = 8'b0010_0000,
    S_FIN_RD = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Stack memory and its registered read port.
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [PTR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  addr_full;

  // Stack and expression state.
  logic [CNT_W-1:0]  cnt;
  logic              dz_seen;
  logic              ovf_seen;
  tok_t              cur;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] res;

  // Divider state.
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [STEP_W-1:0] step;

  // Result register.
  logic              out_valid;
  logic              out_load;

  // Shared combinational values.
  logic [DATA_W-1:0] pop_val;
  logic              do_push;
  logic [DATA_W-1:0] push_data;
  logic              stack_full;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] quo_next;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] prod;

  // The second pop reads one entry deeper than the first.
  assign addr_full = (state == S_POP_B) ? cnt - CNT_W'(2) : cnt - CNT_W'(1);
  assign rd_addr   = addr_full[PTR_W-1:0];

  // Popping an empty stack yields all ones.
  assign pop_val    = (cnt == '0) ? '1 : rdata;
  assign stack_full = (cnt == CNT_W'(STACK_DEPTH));

  assign tok_pop  = (state == S_IDLE) && !tok_empty;
  assign empty    = !out_valid;
  assign out_load = (state == S_FIN) && (!out_valid || pop);

  // Push requests come from number tokens and from finished operators.
  always_comb begin
    do_push   = 1'b0;
    push_data = res;
    if (tok_pop && tok.op == OP_NUM) begin
      do_push   = 1'b1;
      push_data = {1'b0, tok.number};
    end else if (state == S_PUSH && cur.op != OP_DROP) begin
      do_push   = 1'b1;
      push_data = res;
    end
  end

  // Operand magnitudes, one restoring division step and the product.
  always_comb begin
    mag_a    = opa[DATA_W-1] ? -opa : opa;
    mag_b    = opb[DATA_W-1] ? -opb : opb;
    rem_sh   = {rem, quo[DATA_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    ge       = !diff[DATA_W];
    rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    quo_next = {quo[DATA_W-2:0], ge};
    prod     = opa * opb;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!tok_empty) begin
          if (tok.op == OP_NUM) begin
            state_next = tok.last ? S_FIN_RD : S_IDLE;
          end else begin
            state_next = S_POP_B;
          end
        end
      end
      S_POP_B:  state_next = S_POP_A;
      S_POP_A:  state_next = S_EXEC;
      S_EXEC: begin
        state_next = (cur.op == OP_DIV && mag_b != '0) ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        if (step == STEP_W'(DATA_W - 1)) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH:   state_next = cur.last ? S_FIN_RD : S_IDLE;
      S_FIN_RD: state_next = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      dz_seen   <= 1'b0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (do_push) begin
        if (stack_full) begin
          ovf_seen <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      if ((state == S_POP_B || state == S_POP_A) && cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (state == S_EXEC && cur.op == OP_DIV && mag_b == '0) begin
        dz_seen <= 1'b1;
      end
      if (state == S_EXEC) begin
        step <= '0;
      end else if (state == S_DIV) begin
        step <= step + STEP_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
        cnt       <= '0;
        dz_seen   <= 1'b0;
        ovf_seen  <= 1'b0;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operand capture, arithmetic, division data path and result register load.
  always_ff @(posedge clk) begin
    if (tok_pop) begin
      cur <= tok;
    end
    if (state == S_POP_B) begin
      opb <= pop_val;
    end
    if (state == S_POP_A) begin
      opa <= pop_val;
    end
    if (state == S_EXEC) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= opa[DATA_W-1] ^ opb[DATA_W-1];
      case (cur.op)
        OP_ADD:  res <= opa + opb;
        OP_SUB:  res <= opa - opb;
        OP_MUL:  res <= prod;
        default: res <= '0;
      endcase
    end
    if (state == S_DIV) begin
      rem <= rem_next;
      quo <= quo_next;
      if (step == STEP_W'(DATA_W - 1)) begin
        res <= neg ? -quo_next : quo_next;
      end
    end
    if (out_load) begin
      value          <= pop_val;
      div_zero       <= dz_seen;
      stack_overflow <= ovf_seen;
    end
  end

  // Stack memory write and registered read.
  always_ff @(posedge clk) begin
    if (do_push && !stack_full) begin
      mem[cnt[PTR_W-1:0]] <= push_data;
    end
    rdata <= mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds the stack depth");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (cnt == '0 && !dz_seen && !ovf_seen && out_valid))
    else $error("expression state not cleared after a result");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    tok_pop |-> (state == S_IDLE && !tok_empty))
    else $error("token taken while the engine is busy");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state) == S_EXEC) |-> (step == '0 && dvs != '0))
    else $error("divider started without a fresh nonzero divisor");

endmodule

[hw/rtl/postfix_stack_evaluator_core.sv]
// Top level of the postfix stack evaluator: front end, token queue, stack engine.
//
// Usage: tokens of a postfix expression enter on a queue-like port. An item
// (func, number, last) is accepted at a rising edge with push high and full
// low. Results leave on a second queue-like port: while empty is low, value,
// div_zero and stack_overflow show the oldest result, which is taken at an
// edge with pop high. Only a token with last set produces a result.
// Sequence: an accepted token is written into the token queue, then the stack
// engine takes it in idle. A number is pushed at once; add, subtract, multiply
// or an unknown operator go through the pop, pop, execute and push states, and
// a division with a nonzero divisor adds the divider loop (one quotient bit per
// cycle in the restoring divider); a last token adds states to read the stack
// top and load the result register. The engine takes no new token before it
// is back in idle, so a stream of divisions is paced by the divider loop.
// Reset clears the stack count, the sticky flags, the token queue and the
// result register; stack memory contents are not cleared.
// When the receiver stalls, the result is held and the engine waits at its
// next last token; the front keeps accepting items until the queue fills.
module postfix_stack_evaluator_core
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [FUNC_W-1:0] func,
  input  logic [NUM_W-1:0]  number,
  input  logic              last,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] value,
  output logic              div_zero,
  output logic              stack_overflow
);

  logic q_full;
  logic q_wr;
  tok_t q_wdata;
  logic q_rd;
  tok_t q_rdata;
  logic q_empty;

  // Classification of incoming items.
  pse_front u_front (
    .push    (push),
    .full    (full),
    .func    (func),
    .number  (number),
    .last    (last),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Token buffer between the two sides.
  pse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  // Stack execution and result delivery.
  pse_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tok            (q_rdata),
    .tok_empty      (q_empty),
    .tok_pop        (q_rd),
    .empty          (empty),
    .pop            (pop),
    .value          (value),
    .div_zero       (div_zero),
    .stack_overflow (stack_overflow)
  );

endmodule

[dv/pse_result_checker.sv]
// Result checker for the postfix stack evaluator: predicts each expression result and compares.
module pse_result_checker
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [FUNC_W-1:0] func,
  input  logic [NUM_W-1:0]  number,
  input  logic              last,
  input  logic              empty,
  input  logic              pop,
  input  logic [DATA_W-1:0] value,
  input  logic              div_zero,
  input  logic              stack_overflow,
  output int                fail_count,
  output int                outstanding
);

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              div_zero;
    logic              stack_overflow;
  } expr_result_t;

  localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] EMPTY_POP = '1;

  // Expected results of finished expressions, oldest first.
  expr_result_t expected_results[$];

  // Shadow copy of the evaluator stack and its sticky flags.
  logic [DATA_W-1:0] operand_stack [STACK_DEPTH];
  int                stack_used;
  logic              div_zero_flag;
  logic              overflow_flag;
  int                mismatches;

  initial begin
    mismatches = 0;
    stack_used = 0;
    div_zero_flag = 1'b0;
    overflow_flag = 1'b0;
  end

  // A push onto a full stack is dropped and remembered.
  function automatic void push_operand(logic [DATA_W-1:0] v);
    if (stack_used < STACK_DEPTH) begin
      operand_stack[PTR_W'(stack_used)] = v;
      stack_used++;
    end else begin
      overflow_flag = 1'b1;
    end
  endfunction

  // Popping an empty stack yields minus one.
  function automatic logic [DATA_W-1:0] pop_operand();
    if (stack_used == 0) return EMPTY_POP;
    stack_used--;
    return operand_stack[PTR_W'(stack_used)];
  endfunction

  // Signed quotient truncated toward zero; division by zero gives zero.
  function automatic logic [DATA_W-1:0] trunc_quotient(logic [DATA_W-1:0] num,
                                                       logic [DATA_W-1:0] den);
    if (den == '0) begin
      div_zero_flag = 1'b1;
      return '0;
    end
    if (num == MOST_NEGATIVE && den == '1) return MOST_NEGATIVE;
    return $signed(num) / $signed(den);
  endfunction

  // Applies one token to the shadow stack and queues the result on a last token.
  function automatic void eval_token(logic [FUNC_W-1:0] f, logic [NUM_W-1:0] n, logic l);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    expr_result_t      res;
    if (f == FUNC_NUMBER) begin
      push_operand({1'b0, n});
    end else begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (f)
        FUNC_ADD: push_operand(lhs + rhs);
        FUNC_SUB: push_operand(lhs - rhs);
        FUNC_MUL: push_operand(lhs * rhs);
        FUNC_DIV: push_operand(trunc_quotient(lhs, rhs));
        default: ;
      endcase
    end
    if (l) begin
      res.value = pop_operand();
      res.div_zero = div_zero_flag;
      res.stack_overflow = overflow_flag;
      expected_results.push_back(res);
      stack_used = 0;
      div_zero_flag = 1'b0;
      overflow_flag = 1'b0;
    end
  endfunction

  // Compare every popped result, then predict from every accepted item.
  always @(posedge clk) begin
    expr_result_t want;
    if (rst) begin
      expected_results.delete();
      stack_used = 0;
      div_zero_flag = 1'b0;
      overflow_flag = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("value: expected no result, got %h", value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value) begin
            $error("value: expected %h, got %h", want.value, value);
            mismatches++;
          end
          if (div_zero !== want.div_zero) begin
            $error("div_zero: expected %b, got %b", want.div_zero, div_zero);
            mismatches++;
          end
          if (stack_overflow !== want.stack_overflow) begin
            $error("stack_overflow: expected %b, got %b", want.stack_overflow, stack_overflow);
            mismatches++;
          end
        end
      end
      if (push && !full) eval_token(func, number, last);
    end
    fail_count <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

[dv/postfix_stack_evaluator_core_tb.sv]
// Testbench top for the postfix stack evaluator: token stimulus, result drain and verdict.
module postfix_stack_evaluator_core_tb;
  import pse_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_OTHER = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
  localparam logic [FUNC_W-1:0] ARITH_FUNCS [4] = '{FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV};
  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam int TOKEN_TARGET = 1700;
  localparam int DRAIN_START = 1450;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [FUNC_W-1:0] func;
  logic [NUM_W-1:0]  number;
  logic              last;
  logic              empty;
  logic              pop;
  logic [DATA_W-1:0] value;
  logic              div_zero;
  logic              stack_overflow;
  int                fail_count;
  int                outstanding;

  int tokens_sent;
  bit gaps_on;
  bit drain_phase;

  postfix_stack_evaluator_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .number         (number),
    .last           (last),
    .empty          (empty),
    .pop            (pop),
    .value          (value),
    .div_zero       (div_zero),
    .stack_overflow (stack_overflow)
  );

  pse_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .number         (number),
    .last           (last),
    .empty          (empty),
    .pop            (pop),
    .value          (value),
    .div_zero       (div_zero),
    .stack_overflow (stack_overflow),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8000000;
    $display("[postfix_stack_evaluator_core] ERROR");
    $finish;
  end

  // Operand values lean toward zero and small numbers so that division by zero shows up.
  function automatic logic [NUM_W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return NUM_MAX;
      2, 3: return NUM_W'($urandom_range(0, 9));
      default: return NUM_W'($urandom());
    endcase
  endfunction

  // Offers one item and holds it until accepted, with an occasional gap in front.
  task automatic send_token(logic [FUNC_W-1:0] f, logic [NUM_W-1:0] n, logic l);
    if (gaps_on && !drain_phase && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    number <= n;
    last <= l;
    do @(posedge clk); while (full);
    tokens_sent++;
  endtask

  // One random expression: mostly well formed, some deep enough to overflow, some noise.
  task automatic send_expression();
    int pick;
    int nums_left;
    int held;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      len = $urandom_range(60, 70);
      for (int i = 0; i < len; i++) send_token(FUNC_NUMBER, rand_operand(), 1'b0);
      for (int i = 1; i < len; i++)
        send_token(ARITH_FUNCS[2'($urandom_range(0, 3))], NUM_W'($urandom()),
                   i == len - 1);
    end else if (pick < 78) begin
      nums_left = $urandom_range(1, 8);
      held = 0;
      while (nums_left > 0 || held > 1) begin
        if (held >= 2 && (nums_left == 0 || $urandom_range(0, 1) == 1)) begin
          held--;
          send_token(ARITH_FUNCS[2'($urandom_range(0, 3))], NUM_W'($urandom()),
                     nums_left == 0 && held == 1);
        end else begin
          nums_left--;
          held++;
          send_token(FUNC_NUMBER, rand_operand(), nums_left == 0 && held == 1);
        end
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_token(FUNC_W'($urandom_range(0, 7)), NUM_W'($urandom()), i == len - 1);
    end
  endtask

  // Result side: pop is high except in random stall bursts.
  initial begin
    int hold;
    pop = 1'b0;
    hold = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (gaps_on && !drain_phase && $urandom_range(0, 11) == 0) begin
        pop <= 1'b0;
        hold = $urandom_range(1, 19) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Item side: reset, directed expressions, random expressions, then drain and verdict.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    func = FUNC_NUMBER;
    number = '0;
    last = 1'b0;
    tokens_sent = 0;
    gaps_on = 1'b1;
    drain_phase = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Number extremes, each alone as a whole expression.
    send_token(FUNC_NUMBER, '0, 1'b1);
    send_token(FUNC_NUMBER, NUM_MAX, 1'b1);
    // Operators on an empty stack, including the unknown kinds.
    send_token(FUNC_ADD, NUM_MAX, 1'b1);
    send_token(FUNC_OTHER, '0, 1'b1);
    send_token(FUNC_SPARE6, '0, 1'b1);
    send_token(FUNC_SPARE7, NUM_MAX, 1'b1);
    // Division by zero sets the flag, and the next expression starts clean.
    send_token(FUNC_NUMBER, 31'd12, 1'b0);
    send_token(FUNC_NUMBER, '0, 1'b0);
    send_token(FUNC_DIV, '0, 1'b1);
    send_token(FUNC_NUMBER, 31'd5, 1'b1);
    // Most negative value divided by minus one wraps.
    send_token(FUNC_NUMBER, '0, 1'b0);
    send_token(FUNC_NUMBER, NUM_MAX, 1'b0);
    send_token(FUNC_SUB, '0, 1'b0);
    send_token(FUNC_NUMBER, 31'd1, 1'b0);
    send_token(FUNC_SUB, '0, 1'b0);
    send_token(FUNC_NUMBER, '0, 1'b0);
    send_token(FUNC_NUMBER, 31'd1, 1'b0);
    send_token(FUNC_SUB, '0, 1'b0);
    send_token(FUNC_DIV, '0, 1'b1);
    // Negative quotient truncates toward zero.
    send_token(FUNC_NUMBER, '0, 1'b0);
    send_token(FUNC_NUMBER, 31'd7, 1'b0);
    send_token(FUNC_SUB, '0, 1'b0);
    send_token(FUNC_NUMBER, 31'd2, 1'b0);
    send_token(FUNC_DIV, '0, 1'b1);
    // Product wraps modulo two to the 32nd.
    send_token(FUNC_NUMBER, NUM_MAX, 1'b0);
    send_token(FUNC_NUMBER, NUM_MAX, 1'b0);
    send_token(FUNC_MUL, '0, 1'b1);

    while (tokens_sent < TOKEN_TARGET) begin
      drain_phase = tokens_sent > DRAIN_START;
      if ($urandom_range(0, 9) == 0) gaps_on = $urandom_range(0, 3) != 0;
      send_expression();
    end
    push <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[postfix_stack_evaluator_core] OK");
    end else begin
      $display("[postfix_stack_evaluator_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pse_pkg.sv
hw/rtl/pse_front.sv
hw/rtl/pse_queue.sv
hw/rtl/pse_back.sv
hw/rtl/postfix_stack_evaluator_core.sv
dv/pse_result_checker.sv
dv/postfix_stack_evaluator_core_tb.sv
